@@ hdl/nsb_pkg.sv @@
// nsb_pkg: item types, register indexes and fixed constants of the sprite blitter
// no dependencies; used by nibble_sprite_blitter

package nsb_pkg;

  // configuration port shape
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 9;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEST_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_W = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_H = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_X    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_Y    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPRITE_W = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_KEY      = 3'd7;

  // register reset values
  localparam logic [7:0] RST_REGION_W = 8'd2;
  localparam logic [7:0] RST_REGION_H = 8'd1;
  localparam logic [8:0] RST_SPRITE_W = 9'd2;
  localparam logic [4:0] RST_KEY      = 5'd16;

  localparam int unsigned ADDR_W = 15;

  typedef struct packed {
    logic [7:0]  sprite_byte;
    logic [15:0] old_word;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] dest_addr;
    logic [ADDR_W-1:0] src_addr;
    logic [15:0]       write_data;
    logic              write_enable;
    logic              last;
  } out_item_t;

endpackage

@@ hdl/nibble_sprite_blitter.sv @@
// nibble_sprite_blitter: 4bpp sprite to 8bpp framebuffer rectangle blitter with colour key
// depends on nsb_pkg (item types, register indexes, reset values)

// One item in, one item out. Each input item carries one sprite byte (two 4-bit
// pixels, high nibble on the left) and the framebuffer word currently at the
// destination; the result item carries the destination word index, the sprite
// byte index, the merged word, a write enable and a last flag on the final pair
// of the rectangle. The block takes one item every clock cycle while in_stall
// is low: the address math (one small multiply per address), the colour key
// merge and the column/row counter step all sit between the input handshake
// and the output register, which registers each result. A one-entry skid
// stage behind the output register lets the input keep flowing while the
// result side stalls; in_stall rises only once that skid entry is full.
// Configuration writes are registered and should be done while the block is
// idle; they never touch the walk counters, which go back to zero after the
// item flagged last.

module nibble_sprite_blitter #(
  parameter int unsigned FB_WIDTH = 240
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  nsb_pkg::in_item_t                in_data,
  // result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output nsb_pkg::out_item_t               out_data,
  // configuration port
  input  logic                             cfg_we,
  input  logic [nsb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [nsb_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  // framebuffer width as a narrow constant for the row multiply
  localparam int unsigned FBW_BITS = $clog2(FB_WIDTH + 1);
  localparam int unsigned DLIN_W   = 9 + FBW_BITS + 1;
  localparam logic [FBW_BITS-1:0] FB_WIDTH_U = FBW_BITS'(FB_WIDTH);
  localparam int unsigned AW = nsb_pkg::ADDR_W;

  // configuration registers
  logic [7:0] dest_x_r, dest_y_r, region_w_r, region_h_r, src_x_r, src_y_r;
  logic [8:0] sprite_w_r;
  logic [4:0] key_r;

  // walk counters
  logic [6:0] col_r, col_nxt;
  logic [7:0] row_r, row_nxt;

  // output register and skid entry
  logic                out_valid_r, out_valid_nxt;
  nsb_pkg::out_item_t  out_data_r, out_data_nxt;
  logic                skid_valid_r, skid_valid_nxt;
  nsb_pkg::out_item_t  skid_data_r, skid_data_nxt;

  logic               in_acc, out_pop;
  nsb_pkg::out_item_t res;

  // address math
  logic [8:0]        dest_row, src_row;
  logic [DLIN_W-1:0] dest_lin;
  logic [16:0]       src_prod;

  // counter limits
  logic [7:0] pairs;
  logic [8:0] rows;
  logic       row_end, rect_end;

  // colour key
  logic       key_on, left_match, right_match;
  logic [3:0] left_px, right_px;

  assign in_stall  = skid_valid_r;
  assign in_acc    = in_valid && !skid_valid_r;
  assign out_pop   = out_valid_r && !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dest_x_r   <= '0;
      dest_y_r   <= '0;
      region_w_r <= nsb_pkg::RST_REGION_W;
      region_h_r <= nsb_pkg::RST_REGION_H;
      src_x_r    <= '0;
      src_y_r    <= '0;
      sprite_w_r <= nsb_pkg::RST_SPRITE_W;
      key_r      <= nsb_pkg::RST_KEY;
    end else if (cfg_we) begin
      unique case (cfg_index)
        nsb_pkg::REG_DEST_X:   dest_x_r   <= cfg_wdata[7:0];
        nsb_pkg::REG_DEST_Y:   dest_y_r   <= cfg_wdata[7:0];
        nsb_pkg::REG_REGION_W: region_w_r <= cfg_wdata[7:0];
        nsb_pkg::REG_REGION_H: region_h_r <= cfg_wdata[7:0];
        nsb_pkg::REG_SRC_X:    src_x_r    <= cfg_wdata[7:0];
        nsb_pkg::REG_SRC_Y:    src_y_r    <= cfg_wdata[7:0];
        nsb_pkg::REG_SPRITE_W: sprite_w_r <= cfg_wdata;
        nsb_pkg::REG_KEY:      key_r      <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  // destination: ((dest_y + row) * fb_width + dest_x) / 2 + column
  assign dest_row = {1'b0, dest_y_r} + {1'b0, row_r};
  assign dest_lin = DLIN_W'(dest_row) * DLIN_W'(FB_WIDTH_U) + DLIN_W'(dest_x_r);

  // source: (src_y + row) * (sprite_w / 2) + src_x / 2 + column
  assign src_row  = {1'b0, src_y_r} + {1'b0, row_r};
  assign src_prod = 17'(src_row) * 17'(sprite_w_r[8:1]);

  // pixel merge; key of 16 or more means opaque
  assign key_on      = !key_r[4];
  assign left_px     = in_data.sprite_byte[7:4];
  assign right_px    = in_data.sprite_byte[3:0];
  assign left_match  = key_on && (left_px == key_r[3:0]);
  assign right_match = key_on && (right_px == key_r[3:0]);

  // rectangle limits, zero width or height acts as one
  always_comb begin
    pairs = 8'((9'(region_w_r) + 9'd1) >> 1);
    if (pairs == 8'd0) begin
      pairs = 8'd1;
    end
    rows = {1'b0, region_h_r};
    if (rows == 9'd0) begin
      rows = 9'd1;
    end
  end

  assign row_end  = ({1'b0, col_r} + 8'd1) >= pairs;
  assign rect_end = row_end && (({1'b0, row_r} + 9'd1) >= rows);

  always_comb begin
    res.dest_addr    = AW'(dest_lin >> 1) + AW'(col_r);
    res.src_addr     = AW'(src_prod) + AW'(src_x_r[7:1]) + AW'(col_r);
    res.write_data   = {right_match ? in_data.old_word[15:8] : {4'b0, right_px},
                        left_match  ? in_data.old_word[7:0]  : {4'b0, left_px}};
    res.write_enable = !(left_match && right_match);
    res.last         = rect_end;
  end

  // counter step on each accepted item
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (in_acc) begin
      if (rect_end) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (row_end) begin
        col_nxt = '0;
        row_nxt = row_r + 8'd1;
      end else begin
        col_nxt = col_r + 7'd1;
      end
    end
  end

  // output register with skid entry behind it
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || out_pop) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else if (in_acc) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = res;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end else if (in_acc) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r        <= '0;
      row_r        <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      col_r        <= col_nxt;
      row_r        <= row_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

endmodule
